@@ rtl/core/mbnp_pkg.sv @@
// Shared types and constants for the mono button note priority block.
// No dependencies; imported by every module under rtl/core.
package mbnp_pkg;

	localparam int BTN_N   = 5;   // buttons per scan
	localparam int NOTE_W  = 7;   // note offset width
	localparam int BTN_W   = 3;   // button number width
	localparam int CODE_W  = 3;   // active code: 0 none, k+1 button k
	localparam int EVT_MAX = 6;   // most events a scan can cause
	localparam int CNT_W   = 3;   // holds 0..EVT_MAX
	localparam int REG_W   = 3;   // register index width
	localparam int Q_DEPTH = 2;   // scans held between front and back
	localparam int QPTR_W  = 1;
	localparam int QCNT_W  = 2;

	// Register indexes of the write port
	localparam logic [REG_W-1:0] REG_NOTE0 = 3'd0;
	localparam logic [REG_W-1:0] REG_NOTE4 = 3'd4;

	// Note offsets after reset, button 0 to 4
	localparam logic [NOTE_W-1:0] NOTE_RESET [BTN_N] = '{7'd0, 7'd5, 7'd7, 7'd9, 7'd10};

	typedef enum logic [1:0] {
		KIND_GATE    = 2'd0,
		KIND_SET     = 2'd1,
		KIND_RELEASE = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BTN_W-1:0]  btn;
	} evt_t;

	// One classified scan: its event list and how many entries are used
	typedef struct packed {
		logic [CNT_W-1:0]        cnt;
		evt_t [EVT_MAX-1:0]      evt;
	} desc_t;

	typedef logic [BTN_N-1:0][NOTE_W-1:0] note_arr_t;

endpackage

@@ rtl/core/mbnp_front.sv @@
// Front end: takes a pin scan, finds the edges and builds the scan's event list.
// Holds previous_pressed and the active button. Depends on mbnp_pkg.
module mbnp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [4:0]            button_pins,
	output logic                  desc_vld,
	output mbnp_pkg::desc_t       desc
);
	import mbnp_pkg::*;

	logic [BTN_N-1:0]  prev_q;
	logic [CODE_W-1:0] act_q;
	logic [BTN_N-1:0]  pressed;
	logic [BTN_N-1:0]  changed;
	logic [CODE_W-1:0] act_nxt;

	assign pressed = ~button_pins;
	assign changed = pressed ^ prev_q;

	// Visit buttons 0..4 in order, appending events and tracking the active code
	always_comb begin
		logic [CNT_W-1:0] n;
		n       = '0;
		act_nxt = act_q;
		desc    = '0;
		for (int i = 0; i < BTN_N; i++) begin
			if (changed[i]) begin
				if (pressed[i]) begin
					if (act_nxt != CODE_W'(i + 1)) begin
						if (act_nxt == '0) begin
							desc.evt[n] = '{kind: KIND_GATE, btn: BTN_W'(i)};
							n = n + 1'b1;
						end
						desc.evt[n] = '{kind: KIND_SET, btn: BTN_W'(i)};
						n = n + 1'b1;
						act_nxt = CODE_W'(i + 1);
					end
				end else if (act_nxt == CODE_W'(i + 1)) begin
					desc.evt[n] = '{kind: KIND_RELEASE, btn: BTN_W'(i)};
					n = n + 1'b1;
					act_nxt = '0;
				end
			end
		end
		desc.cnt = n;
	end

	// Scans without edges produce nothing for the back end
	assign desc_vld = accept && (desc.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			act_q  <= '0;
		end else if (accept) begin
			prev_q <= pressed;
			act_q  <= act_nxt;
		end
	end

endmodule

@@ rtl/core/mbnp_queue.sv @@
// Short queue of classified scans between the front and the back end.
// Register based, two entries. Depends on mbnp_pkg.
module mbnp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr,
	input  mbnp_pkg::desc_t       wr_desc,
	input  logic                  rd,
	output logic                  full,
	output logic                  nonempty,
	output mbnp_pkg::desc_t       head
);
	import mbnp_pkg::*;

	desc_t             ent_q [Q_DEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(Q_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = ent_q[rp_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (wr)
			ent_q[wp_q] <= wr_desc;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + 1'b1;
			if (rd)
				rp_q <= rp_q + 1'b1;
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/core/mbnp_back.sv @@
// Back end: walks the head scan's event list into the output register, one event
// per cycle while it is free or popped. Looks up note offsets. Depends on mbnp_pkg.
module mbnp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_vld,
	input  mbnp_pkg::desc_t       head,
	input  mbnp_pkg::note_arr_t   notes,
	output logic                  head_done,
	input  logic                  pop,
	output logic                  empty,
	output logic [1:0]            event_kind,
	output logic [6:0]            note_value,
	output logic [2:0]            button_index,
	output logic                  last_event
);
	import mbnp_pkg::*;

	logic [CNT_W-1:0]  idx_q;
	logic              out_vld_q;
	kind_t             kind_q;
	logic [NOTE_W-1:0] note_q;
	logic [BTN_W-1:0]  btn_q;
	logic              last_q;
	logic              load;
	logic              is_last;
	evt_t              cur;

	// Load a new event when the output slot is free or being taken
	assign load      = head_vld && (!out_vld_q || pop);
	assign cur       = head.evt[idx_q];
	assign is_last   = (CNT_W'(idx_q + 1'b1) == head.cnt);
	assign head_done = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= is_last ? '0 : idx_q + 1'b1;
			if (load)
				out_vld_q <= 1'b1;
			else if (pop)
				out_vld_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= cur.kind;
			note_q <= (cur.kind == KIND_SET) ? notes[cur.btn] : '0;
			btn_q  <= cur.btn;
			last_q <= is_last;
		end
	end

	assign empty        = !out_vld_q;
	assign event_kind   = kind_q;
	assign note_value   = note_q;
	assign button_index = btn_q;
	assign last_event   = last_q;

endmodule

@@ rtl/core/mono_button_note_priority.sv @@
// Top level of the mono button note priority block: note registers and wiring.
// Instantiates mbnp_front, mbnp_queue and mbnp_back; depends on mbnp_pkg.

// A scan is taken whenever push is high and full is low: the front end decodes all
// five buttons at once and, if the scan causes any event, stores its event list
// in a two-entry queue. The back end sends one event per cycle from the head of
// that queue while the output is free or popped; a scan that causes no event (a
// scan may cause 0 to 6) never enters the queue. The first event of a scan goes
// through the queue entry and then the output register; full rises only while the
// queue holds two scans, so the sustained rate is set by the back end at one
// event per cycle while pop is held.
module mono_button_note_priority (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [4:0]  button_pins,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  event_kind,
	output logic [6:0]  note_value,
	output logic [2:0]  button_index,
	output logic        last_event,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [6:0]  wr_data
);
	import mbnp_pkg::*;

	note_arr_t notes_q;
	logic      accept;
	logic      desc_vld;
	desc_t     desc;
	logic      q_nonempty;
	desc_t     q_head;
	logic      q_rd;

	// Note offset registers; indexes past the last note are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BTN_N; i++)
				notes_q[i] <= NOTE_RESET[i];
		end else if (wr_en && wr_index >= REG_NOTE0 && wr_index <= REG_NOTE4) begin
			for (int i = 0; i < BTN_N; i++)
				if (wr_index == REG_W'(i))
					notes_q[i] <= wr_data;
		end
	end

	assign accept = push && !full;

	mbnp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.button_pins (button_pins),
		.desc_vld    (desc_vld),
		.desc        (desc)
	);

	mbnp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (desc_vld),
		.wr_desc  (desc),
		.rd       (q_rd),
		.full     (full),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	mbnp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_vld     (q_nonempty),
		.head         (q_head),
		.notes        (notes_q),
		.head_done    (q_rd),
		.pop          (pop),
		.empty        (empty),
		.event_kind   (event_kind),
		.note_value   (note_value),
		.button_index (button_index),
		.last_event   (last_event)
	);

`ifndef SYNTH
	// Every queued scan carries between one and six events
	a_desc_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		desc_vld |-> (desc.cnt != '0) && (desc.cnt <= CNT_W'(EVT_MAX)))
		else $error("queued scan with bad event count");

	// Taking an event that is not a scan's last one exposes the next event at once
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last_event) |=> !empty)
		else $error("gap inside a scan's event list");

	// A gate trigger is always followed by a set-note in the same scan
	a_gate_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_kind == KIND_GATE) |-> !last_event)
		else $error("gate trigger marked as last event");
`endif

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for mono_button_note_priority: button scans in, note events out.
// Depends on mbnp_pkg and the RTL under rtl/core; predicts every event internally.
module tb_top;
	import mbnp_pkg::*;

	localparam logic [BTN_N-1:0] PINS_RELEASED = '1;
	localparam int               SETTLE_CYCLES = 8;
	localparam int               REPORT_LIMIT  = 10;
	localparam int               HOLD_CYCLES   = 80;

	// One predicted event
	typedef struct {
		kind_t             kind;
		logic [NOTE_W-1:0] note;
		logic [BTN_W-1:0]  btn;
		logic              last;
	} note_event_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic [BTN_N-1:0]  button_pins = PINS_RELEASED;
	logic              empty;
	logic              pop = 1'b0;
	logic [1:0]        event_kind;
	logic [NOTE_W-1:0] note_value;
	logic [BTN_W-1:0]  button_index;
	logic              last_event;
	logic              wr_en = 1'b0;
	logic [REG_W-1:0]  wr_index = REG_NOTE0;
	logic [NOTE_W-1:0] wr_data = '0;

	// Scans waiting to be sent, events waiting to be seen
	logic [BTN_N-1:0] scan_queue [$];
	note_event_t      expected_events [$];

	// Shadow state of the handler
	logic [NOTE_W-1:0] note_regs [BTN_N];
	logic [BTN_N-1:0]  held_buttons = '0;
	logic [CODE_W-1:0] sounding_code = '0;

	int send_idle_pct = 11;
	int recv_idle_pct = 56;
	int hold_left = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int mismatch_count = 0;

	mono_button_note_priority dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.button_pins  (button_pins),
		.empty        (empty),
		.pop          (pop),
		.event_kind   (event_kind),
		.note_value   (note_value),
		.button_index (button_index),
		.last_event   (last_event),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Work out the events one scan causes and queue them
	task automatic predict_scan(input logic [BTN_N-1:0] pins);
		logic [BTN_N-1:0] pressed;
		logic [BTN_N-1:0] changed;
		note_event_t      evts [EVT_MAX];
		int               n;
		pressed = ~pins;
		changed = pressed ^ held_buttons;
		n = 0;
		for (int b = 0; b < BTN_N; b++) begin
			if (changed[b]) begin
				if (pressed[b]) begin
					if (sounding_code != CODE_W'(b + 1)) begin
						if (sounding_code == '0) begin
							evts[n] = '{KIND_GATE, '0, BTN_W'(b), 1'b0};
							n++;
						end
						evts[n] = '{KIND_SET, note_regs[b], BTN_W'(b), 1'b0};
						n++;
						sounding_code = CODE_W'(b + 1);
					end
				end else if (sounding_code == CODE_W'(b + 1)) begin
					evts[n] = '{KIND_RELEASE, '0, BTN_W'(b), 1'b0};
					n++;
					sounding_code = '0;
				end
			end
		end
		held_buttons = pressed;
		for (int k = 0; k < n; k++) begin
			evts[k].last = (k == n - 1);
			expected_events.push_back(evts[k]);
		end
	endtask

	// Driver: offer the oldest pending scan; predict on each accepted transaction
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				predict_scan(button_pins);
				void'(scan_queue.pop_front());
			end
			if (scan_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				push <= 1'b1;
				button_pins <= scan_queue[0];
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, started on request and counted down here
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0)
			hold_left <= hold_left - 1;
	end

	// Monitor: compare each popped event with the oldest expectation
	always @(posedge clk) begin
		note_event_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_events.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected event: kind %0d note %0d button %0d last %0b",
							event_kind, note_value, button_index, last_event);
				end else begin
					want = expected_events.pop_front();
					if (event_kind !== want.kind || note_value !== want.note ||
						button_index !== want.btn || last_event !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT)
							$display({"event mismatch: expected kind %0d note %0d button %0d ",
								"last %0b, got kind %0d note %0d button %0d last %0b"},
								want.kind, want.note, want.btn, want.last,
								event_kind, note_value, button_index, last_event);
					end
				end
			end
			pop <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Single register write; indexes past the last button are ignored by the block
	task automatic write_note(input logic [REG_W-1:0] idx, input logic [NOTE_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		if (idx <= REG_NOTE4)
			note_regs[idx - REG_NOTE0] = val;
	endtask

	task automatic end_writes();
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// Wait until every scan is accepted and every event has come out
	task automatic wait_drained();
		do
			@(negedge clk);
		while (scan_queue.size() != 0 || push || expected_events.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly small steps from the last scan, some arbitrary patterns
	task automatic add_random(input int count, inout logic [BTN_N-1:0] walk);
		int r;
		@(negedge clk);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				walk[$urandom_range(0, BTN_N - 1)] ^= 1'b1;
			else if (r < 8) begin
				walk[$urandom_range(0, BTN_N - 1)] ^= 1'b1;
				walk[$urandom_range(0, BTN_N - 1)] ^= 1'b1;
			end else
				walk = BTN_N'($urandom_range(0, 31));
			scan_queue.push_back(walk);
		end
	endtask

	initial begin
		logic [BTN_N-1:0] walk;
		for (int b = 0; b < BTN_N; b++)
			note_regs[b] = NOTE_RESET[b];
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: no edge, all pressed at once, releases of active and idle buttons
		scan_queue = '{5'h1F, 5'h1F, 5'h00, 5'h1F, 5'h1E, 5'h1C, 5'h1E, 5'h1F, 5'h15,
			5'h0A, 5'h0A, 5'h1F, 5'h0F, 5'h1F, 5'h1B, 5'h13, 5'h1B, 5'h00, 5'h01, 5'h1F};
		walk = PINS_RELEASED;
		wait_drained();

		// All notes at the top; out-of-range indexes must leave them alone
		for (int r = 0; r < 2 ** REG_W; r++)
			write_note(REG_W'(r), '1);
		for (int r = REG_NOTE4 + 1; r < 2 ** REG_W; r++)
			write_note(REG_W'(r), NOTE_W'($urandom_range(0, 127)));
		end_writes();
		add_random(50, walk);
		wait_drained();

		// All notes zero, receiver fast, sender slow, with a full pause midway
		send_idle_pct = 56;
		recv_idle_pct = 11;
		for (int b = 0; b < BTN_N; b++)
			write_note(REG_NOTE0 + REG_W'(b), '0);
		end_writes();
		add_random(25, walk);
		wait_drained();
		add_random(25, walk);
		wait_drained();

		// Random notes, no idling, receiver held off so the input backs up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int b = 0; b < BTN_N; b++)
			write_note(REG_NOTE0 + REG_W'(b), NOTE_W'($urandom_range(0, 127)));
		end_writes();
		@(negedge clk);
		hold_req++;
		add_random(50, walk);
		wait_drained();

		if (mismatch_count == 0 && expected_events.size() == 0)
			$display("mono_button_note_priority regression: pass");
		else
			$display("mono_button_note_priority regression: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("mono_button_note_priority regression: fail");
		$finish;
	end

endmodule
